>>> rtl/dlms_pkg.sv
// Shared types and constants of the debounced LED mode sequencer.
package dlms_pkg;

  // Configuration port geometry
  localparam int unsigned CFG_DATA_W  = 16;
  localparam int unsigned CFG_INDEX_W = 3;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_DEBOUNCE_TICKS = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SLOW_PERIOD    = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_NORMAL_PERIOD  = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_FAST_PERIOD    = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_STEP_PERIOD    = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_RANDOM_SEED    = 3'd5;

  // Register reset values
  localparam logic [15:0] RST_DEBOUNCE_TICKS = 16'd150;
  localparam logic [15:0] RST_SLOW_PERIOD    = 16'd1000;
  localparam logic [15:0] RST_NORMAL_PERIOD  = 16'd250;
  localparam logic [15:0] RST_FAST_PERIOD    = 16'd50;
  localparam logic [15:0] RST_STEP_PERIOD    = 16'd300;
  localparam logic [15:0] RST_RANDOM_SEED    = 16'd44257;

  // Galois LFSR tap mask, right shift
  localparam logic [15:0] LFSR_TAPS = 16'hB400;

  // Number of LED drive bits in the level register
  localparam int unsigned LED_W = 4;

  typedef enum logic [2:0] {
    MODE_OFF    = 3'd0,
    MODE_ON     = 3'd1,
    MODE_SLOW   = 3'd2,
    MODE_NORMAL = 3'd3,
    MODE_FAST   = 3'd4,
    MODE_CHASE  = 3'd5,
    MODE_RANDOM = 3'd6
  } mode_t;

endpackage

>>> rtl/debounced_led_mode_sequencer.sv
// A result beat is valid in the cycle after its tick beat is accepted.
// Throughput: one tick per cycle; all state updates in a single pass of
// compares and muxes between the state registers and the output register.
// in_ready drops only while the output register holds a beat not yet taken.
// Reset (rst, synchronous): registers to defaults, mode off, LED levels
// cleared, debouncers released, LFSR loaded with the default seed.
module debounced_led_mode_sequencer
  import dlms_pkg::*;
#(
  parameter int unsigned LED_COUNT = 4
) (
  input  logic                   clk,
  input  logic                   rst,
  // tick channel
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   next_button_raw,
  input  logic                   back_button_raw,
  // result channel
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic                   led_red,
  output logic                   led_blue,
  output logic                   led_green,
  output logic                   led_white,
  output logic [2:0]             mode_now,
  // configuration
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam logic [LED_W-1:0] ALL_MASK = LED_W'((1 << LED_COUNT) - 1);
  localparam logic [1:0]       LAST_IDX = 2'(LED_COUNT - 1);
  localparam bit               COUNT_POW2 = (LED_COUNT != 3);

  // Value mod 3 by base-4 digit sums (4 is 1 mod 3)
  function automatic logic [1:0] mod3_16(input logic [15:0] v);
    logic [4:0] s1;
    logic [2:0] s2;
    s1 = '0;
    for (int i = 0; i < 8; i++) begin
      s1 = s1 + 5'(v[2*i +: 2]);
    end
    s2 = 3'(s1[1:0]) + 3'(s1[3:2]) + 3'(s1[4]);
    if (s2 >= 3'd6) begin
      s2 = s2 - 3'd6;
    end else if (s2 >= 3'd3) begin
      s2 = s2 - 3'd3;
    end
    return s2[1:0];
  endfunction

  function automatic logic [15:0] sat_inc(input logic [15:0] v);
    return (v == '1) ? v : v + 16'd1;
  endfunction

  // Configuration registers
  logic [15:0] debounce_ticks, slow_period, normal_period, fast_period;
  logic [15:0] step_period;

  // Sequencer state
  mode_t       current_mode, current_mode_next;
  logic        next_last_raw, next_last_raw_next;
  logic        next_stable, next_stable_next;
  logic [15:0] next_elapsed, next_elapsed_next;
  logic        back_last_raw, back_last_raw_next;
  logic        back_stable, back_stable_next;
  logic [15:0] back_elapsed, back_elapsed_next;
  logic        blink_phase, blink_phase_next;
  logic [15:0] blink_elapsed, blink_elapsed_next;
  logic [15:0] step_elapsed, step_elapsed_next;
  logic [1:0]  chase_index, chase_index_next;
  logic [LED_W-1:0] led_levels, led_levels_next;
  logic [15:0] lfsr_value, lfsr_value_next;

  // Output register payload
  logic [LED_W-1:0] out_leds;
  mode_t            out_mode;

  logic        accept;
  logic        next_press, back_press;
  logic [15:0] blink_period;
  logic [1:0]  rand_idx;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  // Per-tick state update
  always_comb begin
    current_mode_next  = current_mode;
    next_last_raw_next = next_last_raw;
    next_stable_next   = next_stable;
    back_last_raw_next = back_last_raw;
    back_stable_next   = back_stable;
    blink_phase_next   = blink_phase;
    chase_index_next   = chase_index;
    led_levels_next    = led_levels;
    lfsr_value_next    = lfsr_value;
    next_press         = 1'b0;
    back_press         = 1'b0;
    blink_period       = slow_period;
    rand_idx           = '0;

    // advance all elapsed counters
    next_elapsed_next  = sat_inc(next_elapsed);
    back_elapsed_next  = sat_inc(back_elapsed);
    blink_elapsed_next = sat_inc(blink_elapsed);
    step_elapsed_next  = sat_inc(step_elapsed);

    // debounce the forward button
    if (next_button_raw != next_last_raw) begin
      next_elapsed_next  = '0;
      next_last_raw_next = next_button_raw;
    end
    if (next_elapsed_next > debounce_ticks && next_last_raw_next != next_stable) begin
      next_stable_next = next_last_raw_next;
      next_press       = !next_last_raw_next;
    end
    if (next_press) begin
      current_mode_next  = (current_mode >= MODE_RANDOM) ? MODE_OFF
                                                         : mode_t'(current_mode + 3'd1);
      led_levels_next    = '0;
      blink_phase_next   = 1'b0;
      chase_index_next   = '0;
      blink_elapsed_next = '0;
      step_elapsed_next  = '0;
    end

    // debounce the back button
    if (back_button_raw != back_last_raw) begin
      back_elapsed_next  = '0;
      back_last_raw_next = back_button_raw;
    end
    if (back_elapsed_next > debounce_ticks && back_last_raw_next != back_stable) begin
      back_stable_next = back_last_raw_next;
      back_press       = !back_last_raw_next;
    end
    if (back_press) begin
      current_mode_next  = (current_mode_next == MODE_OFF || current_mode_next > MODE_RANDOM)
                         ? MODE_RANDOM : mode_t'(current_mode_next - 3'd1);
      led_levels_next    = '0;
      blink_phase_next   = 1'b0;
      chase_index_next   = '0;
      blink_elapsed_next = '0;
      step_elapsed_next  = '0;
    end

    // drive the LEDs for the resulting mode
    unique case (current_mode_next)
      MODE_SLOW:   blink_period = slow_period;
      MODE_NORMAL: blink_period = normal_period;
      MODE_FAST:   blink_period = fast_period;
      default:     blink_period = slow_period;
    endcase

    unique case (current_mode_next)
      MODE_ON: begin
        led_levels_next = ALL_MASK;
      end
      MODE_SLOW, MODE_NORMAL, MODE_FAST: begin
        if (blink_elapsed_next >= blink_period) begin
          blink_phase_next   = !blink_phase_next;
          led_levels_next    = blink_phase_next ? ALL_MASK : '0;
          blink_elapsed_next = '0;
        end
      end
      MODE_CHASE: begin
        if (step_elapsed_next >= step_period) begin
          led_levels_next   = LED_W'(1) << chase_index_next;
          chase_index_next  = (chase_index_next == LAST_IDX) ? 2'd0
                                                             : chase_index_next + 2'd1;
          step_elapsed_next = '0;
        end
      end
      MODE_RANDOM: begin
        if (step_elapsed_next >= step_period) begin
          lfsr_value_next = (lfsr_value >> 1) ^ (lfsr_value[0] ? LFSR_TAPS : 16'h0000);
          rand_idx        = COUNT_POW2 ? (lfsr_value_next[1:0] & LAST_IDX)
                                       : mod3_16(lfsr_value_next);
          led_levels_next   = LED_W'(1) << rand_idx;
          step_elapsed_next = '0;
        end
      end
      default: begin
        led_levels_next = '0;
      end
    endcase
  end

  // Configuration writes; a seed write also reloads the LFSR
  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ticks <= RST_DEBOUNCE_TICKS;
      slow_period    <= RST_SLOW_PERIOD;
      normal_period  <= RST_NORMAL_PERIOD;
      fast_period    <= RST_FAST_PERIOD;
      step_period    <= RST_STEP_PERIOD;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_DEBOUNCE_TICKS: debounce_ticks <= cfg_data;
        REG_SLOW_PERIOD:    slow_period    <= cfg_data;
        REG_NORMAL_PERIOD:  normal_period  <= cfg_data;
        REG_FAST_PERIOD:    fast_period    <= cfg_data;
        REG_STEP_PERIOD:    step_period    <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sequencer state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      current_mode  <= MODE_OFF;
      next_last_raw <= 1'b1;
      next_stable   <= 1'b1;
      next_elapsed  <= '0;
      back_last_raw <= 1'b1;
      back_stable   <= 1'b1;
      back_elapsed  <= '0;
      blink_phase   <= 1'b0;
      blink_elapsed <= '0;
      step_elapsed  <= '0;
      chase_index   <= '0;
      led_levels    <= '0;
    end else if (accept) begin
      current_mode  <= current_mode_next;
      next_last_raw <= next_last_raw_next;
      next_stable   <= next_stable_next;
      next_elapsed  <= next_elapsed_next;
      back_last_raw <= back_last_raw_next;
      back_stable   <= back_stable_next;
      back_elapsed  <= back_elapsed_next;
      blink_phase   <= blink_phase_next;
      blink_elapsed <= blink_elapsed_next;
      step_elapsed  <= step_elapsed_next;
      chase_index   <= chase_index_next;
      led_levels    <= led_levels_next;
    end
  end

  // LFSR: load the seed on a seed write, else step in random mode on ticks
  always_ff @(posedge clk) begin
    if (rst) begin
      lfsr_value <= RST_RANDOM_SEED;
    end else if (cfg_write && cfg_index == REG_RANDOM_SEED) begin
      lfsr_value <= cfg_data;
    end else if (accept) begin
      lfsr_value <= lfsr_value_next;
    end
  end

  // Output register: hold the result beat until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_leds <= led_levels_next;
      out_mode <= current_mode_next;
    end
  end

  assign led_red   = out_leds[0];
  assign led_blue  = out_leds[1];
  assign led_green = out_leds[2];
  assign led_white = out_leds[3];
  assign mode_now  = out_mode;

`ifndef SYNTHESIS
  // A stalled result blocks new ticks
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |-> !in_ready)
    else $error("tick accepted while result beat stalled");

  // Off mode keeps every LED dark
  a_off_dark: assert property (@(posedge clk) disable iff (rst)
    (current_mode == MODE_OFF) |-> (led_levels == '0))
    else $error("LED lit in off mode");

  // On mode lights every used LED
  a_on_lit: assert property (@(posedge clk) disable iff (rst)
    (current_mode == MODE_ON) |-> (led_levels == ALL_MASK))
    else $error("LED dark in on mode");

  // LEDs beyond the configured count never light
  a_unused_dark: assert property (@(posedge clk) disable iff (rst)
    accept |=> ((led_levels & ~ALL_MASK) == '0))
    else $error("unused LED lit");
`endif

endmodule

>>> test/tb_debounced_led_mode_sequencer.sv
// Self-checking testbench for the debounced LED mode sequencer.
module tb_debounced_led_mode_sequencer;
  timeunit 1ns;
  timeprecision 1ps;

  import dlms_pkg::*;

  localparam int unsigned N_LEDS      = 4;
  localparam logic [3:0]  ALL_LEDS    = 4'((1 << N_LEDS) - 1);
  localparam int          CYCLE_LIMIT = 200000;
  localparam int          TAIL_CYCLES = 10;

  // One result beat: LED levels (bit0 red .. bit3 white) and the mode
  typedef struct packed {
    logic [3:0] lamps;
    mode_t      mode;
  } led_frame_t;

  // One row of the directed tick table
  typedef struct packed {
    logic       next_raw;
    logic       back_raw;
    logic       typed;
    led_frame_t frame;
  } tick_row_t;

  // Debouncer of one button
  typedef struct packed {
    logic        level;
    logic        settled;
    logic [15:0] age;
    logic        pressed;
  } button_t;

  typedef enum {PACE_STEADY, PACE_SENDER_IDLE, PACE_RECEIVER_STALL, PACE_BOTH} pace_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic                   next_button_raw = 1'b1;
  logic                   back_button_raw = 1'b1;
  logic                   out_valid;
  logic                   out_ready = 1'b1;
  logic                   led_red;
  logic                   led_blue;
  logic                   led_green;
  logic                   led_white;
  logic [2:0]             mode_now;
  logic                   cfg_write = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = REG_DEBOUNCE_TICKS;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  // Shadow registers of the sequencer, tracked by the predictor
  logic [15:0] debounce_limit = RST_DEBOUNCE_TICKS;
  logic [15:0] slow_ticks     = RST_SLOW_PERIOD;
  logic [15:0] normal_ticks   = RST_NORMAL_PERIOD;
  logic [15:0] fast_ticks     = RST_FAST_PERIOD;
  logic [15:0] step_ticks     = RST_STEP_PERIOD;
  mode_t       cur_mode       = MODE_OFF;
  button_t     fwd_btn        = '{1'b1, 1'b1, 16'd0, 1'b0};
  button_t     rev_btn        = '{1'b1, 1'b1, 16'd0, 1'b0};
  logic        blink_on       = 1'b0;
  logic [15:0] blink_age      = '0;
  logic [15:0] step_age       = '0;
  logic [1:0]  chase_pos      = '0;
  logic [3:0]  lamp_bits      = '0;
  logic [15:0] lfsr_reg       = RST_RANDOM_SEED;

  led_frame_t  led_frames_due [$];
  tick_row_t   directed_rows [0:23];
  logic        fault_seen = 1'b0;
  int          idle_pct = 0;
  int          stall_pct = 0;
  int          cycle_count = 0;
  logic        fwd_level = 1'b1;
  logic        rev_level = 1'b1;
  int          fwd_hold = 0;
  int          rev_hold = 0;

  debounced_led_mode_sequencer #(.LED_COUNT(N_LEDS)) DUT (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .next_button_raw (next_button_raw),
    .back_button_raw (back_button_raw),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .led_red         (led_red),
    .led_blue        (led_blue),
    .led_green       (led_green),
    .led_white       (led_white),
    .mode_now        (mode_now),
    .cfg_write       (cfg_write),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------- predictor

  function automatic logic [15:0] sat_inc(input logic [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

  // Restart the age on a raw change; flag a newly settled press
  function automatic button_t settle_button(input button_t btn, input logic raw);
    button_t b;
    b = btn;
    b.pressed = 1'b0;
    if (raw != b.level) begin
      b.age   = '0;
      b.level = raw;
    end
    if (b.age > debounce_limit && b.level != b.settled) begin
      b.settled = b.level;
      b.pressed = (b.settled == 1'b0);
    end
    return b;
  endfunction

  function automatic void enter_mode(input mode_t m);
    cur_mode  = m;
    lamp_bits = '0;
    blink_on  = 1'b0;
    chase_pos = '0;
    blink_age = '0;
    step_age  = '0;
  endfunction

  function automatic void blink_toggle(input logic [15:0] period);
    if (blink_age >= period) begin
      blink_on  = ~blink_on;
      lamp_bits = blink_on ? ALL_LEDS : 4'b0000;
      blink_age = '0;
    end
  endfunction

  // Advance the shadow state by one tick and return the LED frame it shows
  function automatic led_frame_t sequence_tick(input logic next_raw, input logic back_raw);
    logic lsb;
    fwd_btn.age = sat_inc(fwd_btn.age);
    rev_btn.age = sat_inc(rev_btn.age);
    blink_age   = sat_inc(blink_age);
    step_age    = sat_inc(step_age);

    // Forward press first, then back press
    fwd_btn = settle_button(fwd_btn, next_raw);
    if (fwd_btn.pressed)
      enter_mode(cur_mode >= MODE_RANDOM ? MODE_OFF : mode_t'(cur_mode + 3'd1));
    rev_btn = settle_button(rev_btn, back_raw);
    if (rev_btn.pressed)
      enter_mode((cur_mode == MODE_OFF || cur_mode > MODE_RANDOM) ?
                 MODE_RANDOM : mode_t'(cur_mode - 3'd1));

    case (cur_mode)
      MODE_ON:     lamp_bits = ALL_LEDS;
      MODE_SLOW:   blink_toggle(slow_ticks);
      MODE_NORMAL: blink_toggle(normal_ticks);
      MODE_FAST:   blink_toggle(fast_ticks);
      MODE_CHASE: begin
        if (step_age >= step_ticks) begin
          chase_pos = 2'(chase_pos % N_LEDS);
          lamp_bits = '0;
          lamp_bits[chase_pos] = 1'b1;
          chase_pos = 2'((chase_pos + 1) % N_LEDS);
          step_age  = '0;
        end
      end
      MODE_RANDOM: begin
        if (step_age >= step_ticks) begin
          lsb      = lfsr_reg[0];
          lfsr_reg = lfsr_reg >> 1;
          if (lsb) lfsr_reg = lfsr_reg ^ LFSR_TAPS;
          lamp_bits = '0;
          lamp_bits[2'(lfsr_reg % N_LEDS)] = 1'b1;
          step_age  = '0;
        end
      end
      default: lamp_bits = '0;
    endcase
    return '{lamp_bits, cur_mode};
  endfunction

  // ---------------------------------------------------------------- drivers

  task automatic set_pace(input pace_t pace);
    idle_pct  = (pace == PACE_SENDER_IDLE) ? 66 : (pace == PACE_BOTH) ? 14 : 0;
    stall_pct = (pace == PACE_RECEIVER_STALL) ? 66 : (pace == PACE_BOTH) ? 14 : 0;
  endtask

  // Write one register at the next rising edge; mirror it in the shadow
  task automatic write_register(input logic [CFG_INDEX_W-1:0] idx, input logic [15:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      REG_DEBOUNCE_TICKS: debounce_limit = val;
      REG_SLOW_PERIOD:    slow_ticks = val;
      REG_NORMAL_PERIOD:  normal_ticks = val;
      REG_FAST_PERIOD:    fast_ticks = val;
      REG_STEP_PERIOD:    step_ticks = val;
      REG_RANDOM_SEED:    lfsr_reg = val;
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic load_registers(input logic [15:0] dbc, input logic [15:0] slow,
                                input logic [15:0] normal, input logic [15:0] fast,
                                input logic [15:0] step, input logic [15:0] seed);
    write_register(REG_DEBOUNCE_TICKS, dbc);
    write_register(REG_SLOW_PERIOD, slow);
    write_register(REG_NORMAL_PERIOD, normal);
    write_register(REG_FAST_PERIOD, fast);
    write_register(REG_STEP_PERIOD, step);
    write_register(REG_RANDOM_SEED, seed);
    cfg_write <= 1'b0;
  endtask

  // Drop valid and hold until every expected beat has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(negedge clk); while (led_frames_due.size() != 0);
  endtask

  // Offer one tick beat, wait for acceptance, queue its expected frame
  task automatic send_tick(input logic next_raw, input logic back_raw,
                           input logic typed, input led_frame_t typed_frame);
    led_frame_t frame;
    if ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(0, 99) < idle_pct);
    end
    in_valid        <= 1'b1;
    next_button_raw <= next_raw;
    back_button_raw <= back_raw;
    do @(posedge clk); while (!in_ready);
    frame = sequence_tick(next_raw, back_raw);
    led_frames_due.push_back(typed ? typed_frame : frame);
    @(negedge clk);
  endtask

  // Pick how long a button keeps its level: mostly long enough to settle,
  // sometimes a bounce that is too short
  function automatic int pick_hold(input logic level, input logic lazy);
    int settle;
    settle = (debounce_limit > 24) ? 24 : int'(debounce_limit);
    if ($urandom_range(0, 99) < 15) return $urandom_range(1, settle + 1);
    if (level) return settle + 2 + $urandom_range(0, lazy ? 30 : 6);
    return settle + 2 + $urandom_range(0, 3);
  endfunction

  // Press and release both buttons as a user would, with bounces and noise
  task automatic run_button_traffic(input int count, input int pause_at);
    for (int k = 0; k < count; k++) begin
      if (fwd_hold <= 0) begin
        fwd_level = ~fwd_level;
        fwd_hold  = pick_hold(fwd_level, 1'b0);
      end
      if (rev_hold <= 0) begin
        rev_level = ~rev_level;
        rev_hold  = pick_hold(rev_level, 1'b1);
      end
      if (k == pause_at) drain_results();
      if ($urandom_range(0, 99) < 4)
        send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 1'b0, '0);
      else
        send_tick(fwd_level, rev_level, 1'b0, '0);
      fwd_hold--;
      rev_hold--;
    end
  endtask

  // ---------------------------------------------------------------- checker

  always @(negedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  task automatic check_field(input string field, input logic [2:0] due, input logic [2:0] seen);
    if (due !== seen) begin
      $error("%s: expected %0d, got %0d", field, due, seen);
      fault_seen = 1'b1;
    end
  endtask

  // Compare each result beat with the oldest expected frame
  always @(posedge clk) begin
    led_frame_t due;
    if (!rst && out_valid && out_ready) begin
      if (led_frames_due.size() == 0) begin
        $error("result beat with no tick pending");
        fault_seen = 1'b1;
      end else begin
        due = led_frames_due.pop_front();
        check_field("led_red", 3'(due.lamps[0]), 3'(led_red));
        check_field("led_blue", 3'(due.lamps[1]), 3'(led_blue));
        check_field("led_green", 3'(due.lamps[2]), 3'(led_green));
        check_field("led_white", 3'(due.lamps[3]), 3'(led_white));
        check_field("mode_now", due.mode, mode_now);
      end
    end
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[debounced_led_mode_sequencer] ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    // Short presses with a zero debounce time walk through the modes;
    // both buttons at once advance and step back in the same tick
    directed_rows = '{
      '{1'b1, 1'b1, 1'b1, '{4'b0000, MODE_OFF}},
      '{1'b0, 1'b1, 1'b1, '{4'b0000, MODE_OFF}},
      '{1'b0, 1'b1, 1'b1, '{4'b1111, MODE_ON}},
      '{1'b1, 1'b1, 1'b1, '{4'b1111, MODE_ON}},
      '{1'b1, 1'b0, 1'b0, '{4'b0000, MODE_OFF}},
      '{1'b0, 1'b0, 1'b0, '{4'b0000, MODE_OFF}},
      '{1'b0, 1'b1, 1'b0, '{4'b0000, MODE_OFF}},
      '{1'b1, 1'b1, 1'b0, '{4'b0000, MODE_OFF}},
      '{1'b1, 1'b1, 1'b0, '{4'b0000, MODE_OFF}},
      '{1'b0, 1'b1, 1'b0, '{4'b0000, MODE_OFF}},
      '{1'b0, 1'b1, 1'b0, '{4'b0000, MODE_OFF}},
      '{1'b1, 1'b1, 1'b0, '{4'b0000, MODE_OFF}},
      '{1'b1, 1'b1, 1'b0, '{4'b0000, MODE_OFF}},
      '{1'b0, 1'b1, 1'b0, '{4'b0000, MODE_OFF}},
      '{1'b0, 1'b1, 1'b0, '{4'b0000, MODE_OFF}},
      '{1'b1, 1'b1, 1'b0, '{4'b0000, MODE_OFF}},
      '{1'b1, 1'b1, 1'b0, '{4'b0000, MODE_OFF}},
      '{1'b0, 1'b0, 1'b0, '{4'b0000, MODE_OFF}},
      '{1'b0, 1'b0, 1'b0, '{4'b0000, MODE_OFF}},
      '{1'b1, 1'b1, 1'b0, '{4'b0000, MODE_OFF}},
      '{1'b1, 1'b1, 1'b0, '{4'b0000, MODE_OFF}},
      '{1'b1, 1'b0, 1'b0, '{4'b0000, MODE_OFF}},
      '{1'b1, 1'b0, 1'b0, '{4'b0000, MODE_OFF}},
      '{1'b1, 1'b1, 1'b0, '{4'b0000, MODE_OFF}}
    };

    // Hold reset, then release it on a falling edge
    repeat (9) @(negedge clk);
    rst <= 1'b0;

    // Directed ticks: zero periods act every tick, zero seed pins the LFSR
    set_pace(PACE_STEADY);
    load_registers(16'd0, 16'd0, 16'd1, 16'd2, 16'd0, 16'd0);
    foreach (directed_rows[i])
      send_tick(directed_rows[i].next_raw, directed_rows[i].back_raw,
                directed_rows[i].typed, directed_rows[i].frame);

    // Random button traffic under several settings and paces
    drain_results();
    load_registers(16'd1, 16'd3, 16'd2, 16'd1, 16'd2, 16'hACE1);
    run_button_traffic(170, -1);

    drain_results();
    set_pace(PACE_SENDER_IDLE);
    load_registers(16'd2, 16'd6, 16'd4, 16'd1, 16'd5, 16'd1);
    run_button_traffic(170, 85);

    drain_results();
    set_pace(PACE_RECEIVER_STALL);
    load_registers(16'd0, 16'hFFFF, 16'd1, 16'd1, 16'd1, 16'hFFFF);
    run_button_traffic(170, -1);

    drain_results();
    set_pace(PACE_BOTH);
    load_registers(16'd3, 16'd2, 16'd2, 16'd3, 16'd3, 16'h8000);
    run_button_traffic(170, -1);

    // Longest debounce time: no press is ever accepted
    drain_results();
    set_pace(PACE_STEADY);
    load_registers(16'hFFFF, 16'd1, 16'd1, 16'd1, 16'hFFFF, 16'($urandom_range(1, 65535)));
    run_button_traffic(80, -1);

    drain_results();
    set_pace(PACE_SENDER_IDLE);
    load_registers(16'($urandom_range(0, 4)), 16'($urandom_range(1, 8)),
                   16'($urandom_range(1, 8)), 16'($urandom_range(1, 8)),
                   16'($urandom_range(1, 8)), 16'($urandom_range(1, 65535)));
    run_button_traffic(150, -1);

    drain_results();
    set_pace(PACE_RECEIVER_STALL);
    load_registers(16'($urandom_range(0, 4)), 16'($urandom_range(1, 8)),
                   16'($urandom_range(1, 8)), 16'($urandom_range(1, 8)),
                   16'($urandom_range(1, 8)), 16'($urandom_range(1, 65535)));
    run_button_traffic(150, -1);

    drain_results();
    set_pace(PACE_BOTH);
    load_registers(16'($urandom_range(0, 4)), 16'($urandom_range(1, 8)),
                   16'($urandom_range(1, 8)), 16'($urandom_range(1, 8)),
                   16'($urandom_range(1, 8)), 16'($urandom_range(1, 65535)));
    run_button_traffic(150, -1);

    // Let the last beats come back, then report
    drain_results();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (!fault_seen && led_frames_due.size() == 0)
      $display("[debounced_led_mode_sequencer] OK");
    else
      $display("[debounced_led_mode_sequencer] ERROR");
    $finish;
  end

endmodule

>>> files.f
rtl/dlms_pkg.sv
rtl/debounced_led_mode_sequencer.sv
test/tb_debounced_led_mode_sequencer.sv
